// ===== src/sacl_pkg.sv =====
// sacl_pkg: shared constants, types and controller/datapath interface structs
// for the set-associative lru cache tag model. no dependencies.

package sacl_pkg;

    localparam int ADDR_BITS   = 32;
    localparam int SETS        = 64;
    localparam int BLOCK_BYTES = 64;
    localparam int WAYS        = 4;

    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int SET_W  = $clog2(SETS);
    localparam int TAG_W  = ADDR_BITS - OFF_W - SET_W;
    localparam int WAY_W  = $clog2(WAYS);
    localparam int RANK_W = $clog2(WAYS);
    // rank compare width: must hold WAYS itself for the fill case
    localparam int OLDR_W = $clog2(WAYS + 1);
    localparam int CNT_W  = 32;

    localparam int IN_TDATA_W   = ((ADDR_BITS + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 1 + 2 + 6 + 1 + CNT_W + CNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [TAG_W-1:0]  tag_t;
    typedef logic [RANK_W-1:0] rank_t;

    // one memory row holds the tags and recency ranks of all ways of a set
    typedef struct packed {
        tag_t  [WAYS-1:0] tags;
        rank_t [WAYS-1:0] ranks;
    } row_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic load;    // capture address, read the set's row
        logic commit;  // write back row, update counters, load result
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

// ===== src/sacl_ctrl.sv =====
// sacl_ctrl: sequencing state machine for the cache lookup.
// depends on sacl_pkg for state, command and status types.

module sacl_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  sacl_pkg::stat_t  stat,
    output sacl_pkg::cmd_t   cmd
);

    sacl_pkg::state_t state_reg;
    sacl_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sacl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            sacl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = sacl_pkg::ST_LOOKUP;
                end
            end
            sacl_pkg::ST_LOOKUP: begin
                // hold here while the previous result is still unclaimed
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = sacl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sacl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/sacl_dp.sv =====
// sacl_dp: tag/rank memory, valid bits, hit/victim selection, lru update,
// counters and result register. depends on sacl_pkg.

module sacl_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  sacl_pkg::cmd_t                     cmd,
    output sacl_pkg::stat_t                    stat,
    input  logic [sacl_pkg::ADDR_BITS-1:0]     s_addr,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sacl_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int WAY_W  = sacl_pkg::WAY_W;
    localparam int RANK_W = sacl_pkg::RANK_W;
    localparam int OLDR_W = sacl_pkg::OLDR_W;
    localparam int CNT_W  = sacl_pkg::CNT_W;
    localparam int PAD_W  = sacl_pkg::OUT_TDATA_W - sacl_pkg::OUT_FIELDS_W;

    logic [sacl_pkg::ADDR_BITS-1:0]            addr_reg;
    sacl_pkg::row_t                            row_mem [sacl_pkg::SETS];
    sacl_pkg::row_t                            row_reg;
    sacl_pkg::row_t                            row_next;
    logic [sacl_pkg::SETS-1:0][sacl_pkg::WAYS-1:0] valid_reg;

    logic [sacl_pkg::SET_W-1:0] set_rd;
    logic [sacl_pkg::SET_W-1:0] set_cur;
    sacl_pkg::tag_t             tag_cur;
    logic [sacl_pkg::WAYS-1:0]  vld_row;

    logic              hit;
    logic [WAY_W-1:0]  hit_way;
    logic              free_found;
    logic [WAY_W-1:0]  free_way;
    logic [WAY_W-1:0]  vic_way;
    logic [WAY_W-1:0]  way_sel;
    logic [OLDR_W-1:0] old_rank;
    logic              evicted;

    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_next;

    logic                       out_valid_reg;
    logic                       out_hit_reg;
    logic [WAY_W-1:0]           out_way_reg;
    logic [sacl_pkg::SET_W-1:0] out_set_reg;
    logic                       out_evict_reg;

    assign set_rd  = s_addr[sacl_pkg::OFF_W +: sacl_pkg::SET_W];
    assign set_cur = addr_reg[sacl_pkg::OFF_W +: sacl_pkg::SET_W];
    assign tag_cur = addr_reg[sacl_pkg::OFF_W + sacl_pkg::SET_W +: sacl_pkg::TAG_W];
    assign vld_row = valid_reg[set_cur];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg <= s_addr;
        end
    end

    // one row per set, read on accept, written back at commit
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            row_reg <= row_mem[set_rd];
        end
        if (cmd.commit) begin
            row_mem[set_cur] <= row_next;
        end
    end

    always_comb begin
        hit        = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        vic_way    = '0;
        for (int w = 0; w < sacl_pkg::WAYS; w++) begin
            if (!hit && vld_row[w] && row_reg.tags[w] == tag_cur) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!free_found && !vld_row[w]) begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
        end
        // lowest way among those with the oldest rank
        for (int w = 1; w < sacl_pkg::WAYS; w++) begin
            if (row_reg.ranks[w] > row_reg.ranks[vic_way]) begin
                vic_way = WAY_W'(w);
            end
        end

        priority if (hit) begin
            way_sel  = hit_way;
            old_rank = OLDR_W'(row_reg.ranks[hit_way]);
        end else if (free_found) begin
            way_sel  = free_way;
            old_rank = OLDR_W'(sacl_pkg::WAYS);
        end else begin
            way_sel  = vic_way;
            old_rank = OLDR_W'(row_reg.ranks[vic_way]);
        end
        evicted = !hit && !free_found;

        row_next = row_reg;
        for (int v = 0; v < sacl_pkg::WAYS; v++) begin
            if (WAY_W'(v) == way_sel) begin
                row_next.ranks[v] = '0;
            end else if (vld_row[v] && OLDR_W'(row_reg.ranks[v]) < old_rank) begin
                row_next.ranks[v] = row_reg.ranks[v] + RANK_W'(1);
            end
        end
        if (!hit) begin
            row_next.tags[way_sel] = tag_cur;
        end

        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (hit) begin
            if (hit_cnt_reg != '1) begin
                hit_cnt_next = hit_cnt_reg + CNT_W'(1);
            end
        end else begin
            if (miss_cnt_reg != '1) begin
                miss_cnt_next = miss_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                valid_reg[set_cur][way_sel] <= 1'b1;
                hit_cnt_reg   <= hit_cnt_next;
                miss_cnt_reg  <= miss_cnt_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_hit_reg   <= hit;
            out_way_reg   <= way_sel;
            out_set_reg   <= set_cur;
            out_evict_reg <= evicted;
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {{PAD_W{1'b0}}, miss_cnt_reg, hit_cnt_reg, out_evict_reg,
                            out_set_reg, out_way_reg, out_hit_reg};

endmodule

// ===== src/set_assoc_cache_lru_top.sv =====
// set_assoc_cache_lru_top: top level of the set-associative lru tag model.
// depends on sacl_pkg, sacl_ctrl and sacl_dp.
//
//  channel   dir   tdata fields (low bit up)
//  s_        in    access_address[31:0]
//  m_        out   hit, way_used[1:0], set_used[5:0], evicted_valid,
//                  hit_total[31:0], miss_total[31:0], zero pad
//
// each access first reads the set's tag/rank row from the single-port set
// memory on accept, then compares, picks the way and writes the row back.
// reset clears the valid bits, counters and result valid flag at once; no
// clearing pass is needed since tags and ranks of invalid lines are never used.
// the result waits in an output register; the lookup stalls only while a
// previous result is still unclaimed.

module set_assoc_cache_lru_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sacl_pkg::IN_TDATA_W-1:0]     s_tdata,   // access_address
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit, way_used, set_used, evicted_valid, hit_total, miss_total, pad
    output logic [sacl_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    sacl_pkg::cmd_t  cmd;
    sacl_pkg::stat_t stat;

    sacl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sacl_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_addr   (s_tdata[sacl_pkg::ADDR_BITS-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sim/cache_access_checker.sv =====
// cache_access_checker: watches both stream channels of the lru cache tag model,
// predicts each result from its own copy of the tag, valid and rank state
// and compares field by field. depends on sacl_pkg.
`timescale 1ns / 100ps

module cache_access_checker
    import sacl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    output int                     mismatches,
    output int                     pending,
    output int                     results_checked,
    output int                     hits_checked,
    output int                     evictions_checked
);

    typedef struct {
        logic              hit;
        logic [WAY_W-1:0]  way_used;
        logic [SET_W-1:0]  set_used;
        logic              evicted_valid;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  miss_total;
    } access_result_t;

    tag_t             line_tag   [SETS][WAYS];
    logic             line_valid [SETS][WAYS];
    int               line_rank  [SETS][WAYS];
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;

    access_result_t   expected_results[$];

    // way w becomes most recent; valid ways younger than old_rank age by one
    task automatic promote_way(input int s, input int w, input int old_rank);
        for (int v = 0; v < WAYS; v++) begin
            if (v != w && line_valid[s][v] && line_rank[s][v] < old_rank)
                line_rank[s][v]++;
        end
        line_rank[s][w] = 0;
    endtask

    task automatic predict_lookup(input logic [ADDR_BITS-1:0] addr,
                                  output access_result_t r);
        int   s;
        int   way;
        tag_t t;
        bit   found;
        s     = int'(addr[OFF_W +: SET_W]);
        t     = addr[OFF_W + SET_W +: TAG_W];
        way   = 0;
        found = 0;
        r.hit = 1'b0;
        r.evicted_valid = 1'b0;
        for (int v = 0; v < WAYS; v++) begin
            if (!found && line_valid[s][v] && line_tag[s][v] == t) begin
                found = 1;
                way   = v;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            promote_way(s, way, line_rank[s][way]);
            if (hit_count != '1)
                hit_count++;
        end else begin
            if (miss_count != '1)
                miss_count++;
            for (int v = 0; v < WAYS; v++) begin
                if (!found && !line_valid[s][v]) begin
                    found = 1;
                    way   = v;
                end
            end
            if (found) begin
                promote_way(s, way, WAYS);
                line_valid[s][way] = 1'b1;
            end else begin
                // full set: oldest rank loses, lowest way on a tie
                for (int v = 1; v < WAYS; v++) begin
                    if (line_rank[s][v] > line_rank[s][way])
                        way = v;
                end
                r.evicted_valid = 1'b1;
                promote_way(s, way, line_rank[s][way]);
            end
            line_tag[s][way] = t;
        end
        r.way_used   = WAY_W'(way);
        r.set_used   = SET_W'(s);
        r.hit_total  = hit_count;
        r.miss_total = miss_count;
    endtask

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        access_result_t got;
        access_result_t want;
        if (!aresetn) begin
            for (int s = 0; s < SETS; s++) begin
                for (int w = 0; w < WAYS; w++) begin
                    line_tag[s][w]   = '0;
                    line_valid[s][w] = 1'b0;
                    line_rank[s][w]  = 0;
                end
            end
            hit_count  = '0;
            miss_count = '0;
            expected_results.delete();
            pending = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.hit           = m_tdata[0];
                got.way_used      = m_tdata[2:1];
                got.set_used      = m_tdata[8:3];
                got.evicted_valid = m_tdata[9];
                got.hit_total     = m_tdata[41:10];
                got.miss_total    = m_tdata[73:42];
                if (expected_results.size() == 0) begin
                    $error("result transaction with no access waiting");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("hit", CNT_W'(want.hit), CNT_W'(got.hit));
                    check_field("way_used", CNT_W'(want.way_used), CNT_W'(got.way_used));
                    check_field("set_used", CNT_W'(want.set_used), CNT_W'(got.set_used));
                    check_field("evicted_valid", CNT_W'(want.evicted_valid),
                                CNT_W'(got.evicted_valid));
                    check_field("hit_total", want.hit_total, got.hit_total);
                    check_field("miss_total", want.miss_total, got.miss_total);
                    results_checked++;
                    if (want.hit)
                        hits_checked++;
                    if (want.evicted_valid)
                        evictions_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_lookup(s_tdata[ADDR_BITS-1:0], want);
                expected_results.push_back(want);
            end
            pending = expected_results.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// testbench: drives address transactions into set_assoc_cache_lru_top with random
// gaps and output stalls; checking is done by cache_access_checker.
// depends on sacl_pkg, set_assoc_cache_lru_top and cache_access_checker.
`timescale 1ns / 100ps

module testbench;
    import sacl_pkg::*;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // access_address
    logic                   m_tvalid;
    logic                   m_tready;
    // hit, way_used, set_used, evicted_valid, hit_total, miss_total, pad
    logic [OUT_TDATA_W-1:0] m_tdata;

    int mismatches;
    int pending;
    int results_checked;
    int hits_checked;
    int evictions_checked;
    int accesses_sent;
    bit hold_request;

    set_assoc_cache_lru_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    cache_access_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .mismatches        (mismatches),
        .pending           (pending),
        .results_checked   (results_checked),
        .hits_checked      (hits_checked),
        .evictions_checked (evictions_checked)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic logic [ADDR_BITS-1:0] make_addr(input logic [TAG_W-1:0] t,
                                                       input logic [SET_W-1:0] s,
                                                       input logic [OFF_W-1:0] off);
        return {t, s, off};
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_access(input logic [ADDR_BITS-1:0] addr, input int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        do @(posedge aclk); while (!s_tready);
        accesses_sent++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    // result side: random stalls, calm stretches, one long hold-off on request
    initial begin : receiver
        int  stall_left;
        bit  calm;
        int  r;
        stall_left = 0;
        calm       = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                hold_request = 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 127) == 0)
                    calm = !calm;
                if (!calm && $urandom_range(0, 3) == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        stall_left = $urandom_range(1, 3);
                    else if (r < 95)
                        stall_left = $urandom_range(4, 12);
                    else
                        stall_left = $urandom_range(30, 80);
                end
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial begin : stimulus
        logic [ADDR_BITS-1:0] directed_addrs[$];
        logic [SET_W-1:0]     hot_sets[4];
        logic [TAG_W-1:0]     tag_base;
        logic [ADDR_BITS-1:0] addr;
        bit                   calm;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        hold_request = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // address extremes, a set filled then replaced, repeated same-set hits
        directed_addrs = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFC0,
            make_addr(20'd1, 6'd5, 6'd0),  make_addr(20'd2, 6'd5, 6'd63),
            make_addr(20'd3, 6'd5, 6'd17), make_addr(20'd4, 6'd5, 6'd32),
            make_addr(20'd2, 6'd5, 6'd5),  make_addr(20'd5, 6'd5, 6'd0),
            make_addr(20'd1, 6'd5, 6'd1),  make_addr(20'd4, 6'd5, 6'd2),
            make_addr(20'd4, 6'd5, 6'd3),  32'h0000_003F,
            make_addr(20'd6, 6'd9, 6'd0),  make_addr(20'd7, 6'd9, 6'd0),
            make_addr(20'd6, 6'd9, 6'd8),  make_addr(20'd7, 6'd9, 6'd9),
            32'h8000_0000, 32'h7FFF_FFFF, make_addr(20'd3, 6'd5, 6'd0)
        };
        foreach (directed_addrs[i])
            send_access(directed_addrs[i], (i % 3 == 0) ? pick_gap(1'b0) : 0);
        drain_results();

        for (int g = 0; g < 17; g++) begin
            foreach (hot_sets[k])
                hot_sets[k] = SET_W'($urandom_range(0, SETS - 1));
            tag_base = TAG_W'($urandom());
            calm     = ($urandom_range(0, 3) == 0);
            if (g == 4) begin
                // sender keeps going while the result side is held off
                hold_request = 1'b1;
                calm         = 1'b1;
            end
            if (g == 9)
                drain_results();
            for (int n = 0; n < 40; n++) begin
                // six tags over four ways keeps both hits and evictions frequent
                if ($urandom_range(0, 9) < 8)
                    addr = make_addr(tag_base ^ TAG_W'($urandom_range(0, 5)),
                                     hot_sets[2'($urandom_range(0, 3))],
                                     OFF_W'($urandom_range(0, BLOCK_BYTES - 1)));
                else
                    addr = $urandom();
                send_access(addr, pick_gap(calm));
            end
        end

        drain_results();
        repeat (10) @(negedge aclk);
        $display("testbench: %0d accesses, %0d results checked, %0d hits, %0d evictions",
                 accesses_sent, results_checked, hits_checked, evictions_checked);
        if (mismatches == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== files.f =====
src/sacl_pkg.sv
src/sacl_ctrl.sv
src/sacl_dp.sv
src/set_assoc_cache_lru_top.sv
sim/cache_access_checker.sv
sim/testbench.sv
